// ===== src/depq_pkg.sv =====
package depq_pkg;

  localparam int unsigned ID_W   = 16;
  localparam int unsigned PRIO_W = 8;
  localparam int unsigned KEY_W  = PRIO_W + ID_W;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_POP_MIN = 2'd1,
    OP_POP_MAX = 2'd2,
    OP_REMOVE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DUP   = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_CMP,
    FSM_EXEC
  } fsm_t;

  typedef enum logic [1:0] {
    MODE_HOLD,
    MODE_LOAD,
    MODE_FROM_LOW,
    MODE_FROM_HIGH
  } cell_mode_t;

  typedef struct packed {
    logic       cmp_en;
    cell_mode_t mode;
  } cell_ctrl_t;

  typedef struct packed {
    logic lt;
    logic eq;
    logic match;
  } cell_flags_t;

endpackage

// ===== src/depq_cell.sv =====
module depq_cell (
  input  logic                            clk,
  input  logic                            rst,
  input  depq_pkg::cell_ctrl_t            ctrl,
  input  logic [depq_pkg::PRIO_W-1:0]     new_prio,
  input  logic [depq_pkg::ID_W-1:0]       new_id,
  input  logic                            low_valid,
  input  logic [depq_pkg::PRIO_W-1:0]     low_prio,
  input  logic [depq_pkg::ID_W-1:0]       low_id,
  input  logic                            high_valid,
  input  logic [depq_pkg::PRIO_W-1:0]     high_prio,
  input  logic [depq_pkg::ID_W-1:0]       high_id,
  output logic                            valid,
  output logic [depq_pkg::PRIO_W-1:0]     prio,
  output logic [depq_pkg::ID_W-1:0]       id,
  output depq_pkg::cell_flags_t           flags
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (ctrl.mode)
        depq_pkg::MODE_HOLD:      valid <= valid;
        depq_pkg::MODE_LOAD:      valid <= 1'b1;
        depq_pkg::MODE_FROM_LOW:  valid <= low_valid;
        depq_pkg::MODE_FROM_HIGH: valid <= high_valid;
        default:                  valid <= valid;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.mode)
      depq_pkg::MODE_HOLD: begin
        prio <= prio;
        id   <= id;
      end
      depq_pkg::MODE_LOAD: begin
        prio <= new_prio;
        id   <= new_id;
      end
      depq_pkg::MODE_FROM_LOW: begin
        prio <= low_prio;
        id   <= low_id;
      end
      depq_pkg::MODE_FROM_HIGH: begin
        prio <= high_prio;
        id   <= high_id;
      end
      default: begin
        prio <= prio;
        id   <= id;
      end
    endcase
  end

  // compare against the request held at the top, invalid cells never flag
  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      flags.lt    <= valid && ({prio, id} < {new_prio, new_id});
      flags.eq    <= valid && ({prio, id} == {new_prio, new_id});
      flags.match <= valid && (id == new_id);
    end
  end

endmodule

// ===== src/depq_scan.sv =====
module depq_scan #(
  parameter int unsigned N = 16
) (
  input  logic [N-1:0] din,
  output logic [N-1:0] dout
);

  localparam int unsigned LEVELS = (N > 1) ? $clog2(N) : 1;

  logic [N-1:0] lvl [LEVELS+1];

  assign lvl[0] = din;

  // inclusive prefix or, log depth
  for (genvar k = 0; k < LEVELS; k++) begin : g_lvl
    for (genvar i = 0; i < N; i++) begin : g_bit
      if (i >= (1 << k)) begin : g_or
        assign lvl[k+1][i] = lvl[k][i] | lvl[k][i-(1<<k)];
      end else begin : g_pass
        assign lvl[k+1][i] = lvl[k][i];
      end
    end
  end

  assign dout = lvl[LEVELS];

endmodule

// ===== src/depq_or_tree.sv =====
module depq_or_tree #(
  parameter int unsigned N = 16,
  parameter int unsigned W = 24
) (
  input  logic [W-1:0] din [N],
  output logic [W-1:0] dout
);

  localparam int unsigned P = (N > 1) ? (1 << $clog2(N)) : 2;

  logic [W-1:0] node [2*P-1];

  for (genvar i = 0; i < P; i++) begin : g_leaf
    if (i < N) begin : g_used
      assign node[P-1+i] = din[i];
    end else begin : g_pad
      assign node[P-1+i] = '0;
    end
  end

  for (genvar i = 0; i < P - 1; i++) begin : g_node
    assign node[i] = node[2*i+1] | node[2*i+2];
  end

  assign dout = node[0];

endmodule

// ===== src/double_ended_priority_queue.sv =====
// channel | handshake            | payload
// input   | in_valid / in_stall  | opcode, proc_id, priority_req
// output  | out_valid / out_stall| status, out_id, out_priority
//
// each item passes CMP, which compares the request in every cell, then EXEC,
// which selects the result and shifts the chain; a new item is taken in EXEC.
// the result lands in an output register, so a stalled result holds only
// the EXEC state of the next item, not its compare.
// reset empties the chain, stored payload is left as is.
module double_ended_priority_queue #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  opcode,
  input  logic [depq_pkg::ID_W-1:0]   proc_id,
  input  logic [depq_pkg::PRIO_W-1:0] priority_req,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  status,
  output logic [depq_pkg::ID_W-1:0]   out_id,
  output logic [depq_pkg::PRIO_W-1:0] out_priority
);

  depq_pkg::fsm_t  state, state_next;
  depq_pkg::op_t   req_op;
  logic [depq_pkg::ID_W-1:0]   req_id;
  logic [depq_pkg::PRIO_W-1:0] req_prio;

  logic accept, out_free, commit;

  logic [CAPACITY-1:0] valid_v, lt_v, eq_v, match_v;
  logic [CAPACITY-1:0] valid_up, suf_up, pre_eq, pre_match, rev_match, rev_pre, suf_match;
  logic [CAPACITY-1:0] sel, take;
  logic [depq_pkg::PRIO_W-1:0] prio_a [CAPACITY];
  logic [depq_pkg::ID_W-1:0]   id_a   [CAPACITY];
  depq_pkg::cell_flags_t       flags_a [CAPACITY];
  depq_pkg::cell_ctrl_t        ctrl_a  [CAPACITY];
  logic [depq_pkg::KEY_W-1:0]  sel_data [CAPACITY];
  logic [depq_pkg::KEY_W-1:0]  tree_out;

  depq_pkg::status_t res_status;
  logic              res_ok, ins_ok;

  assign out_free = !out_valid || !out_stall;
  assign commit   = (state == depq_pkg::FSM_EXEC) && out_free;
  assign in_stall = !((state == depq_pkg::FSM_IDLE) || commit);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= depq_pkg::FSM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      depq_pkg::FSM_IDLE: begin
        if (accept) state_next = depq_pkg::FSM_CMP;
      end
      depq_pkg::FSM_CMP: begin
        state_next = depq_pkg::FSM_EXEC;
      end
      depq_pkg::FSM_EXEC: begin
        if (commit) state_next = accept ? depq_pkg::FSM_CMP : depq_pkg::FSM_IDLE;
      end
      default: state_next = depq_pkg::FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_op   <= depq_pkg::op_t'(opcode);
      req_id   <= proc_id;
      req_prio <= priority_req;
    end
  end

  // cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                        lo_v, hi_v;
    logic [depq_pkg::PRIO_W-1:0] lo_p, hi_p;
    logic [depq_pkg::ID_W-1:0]   lo_i, hi_i;

    if (i == 0) begin : g_lo_edge
      assign lo_v = 1'b0;
      assign lo_p = '0;
      assign lo_i = '0;
    end else begin : g_lo
      assign lo_v = valid_v[i-1];
      assign lo_p = prio_a[i-1];
      assign lo_i = id_a[i-1];
    end

    if (i == CAPACITY - 1) begin : g_hi_edge
      assign hi_v        = 1'b0;
      assign hi_p        = '0;
      assign hi_i        = '0;
      assign valid_up[i] = 1'b0;
      assign suf_up[i]   = 1'b0;
    end else begin : g_hi
      assign hi_v        = valid_v[i+1];
      assign hi_p        = prio_a[i+1];
      assign hi_i        = id_a[i+1];
      assign valid_up[i] = valid_v[i+1];
      assign suf_up[i]   = suf_match[i+1];
    end

    depq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl_a[i]),
      .new_prio   (req_prio),
      .new_id     (req_id),
      .low_valid  (lo_v),
      .low_prio   (lo_p),
      .low_id     (lo_i),
      .high_valid (hi_v),
      .high_prio  (hi_p),
      .high_id    (hi_i),
      .valid      (valid_v[i]),
      .prio       (prio_a[i]),
      .id         (id_a[i]),
      .flags      (flags_a[i])
    );

    assign lt_v[i]      = flags_a[i].lt;
    assign eq_v[i]      = flags_a[i].eq;
    assign match_v[i]   = flags_a[i].match;
    assign rev_match[i] = match_v[CAPACITY-1-i];
    assign suf_match[i] = rev_pre[CAPACITY-1-i];

    // removal target and the cells at or above it
    always_comb begin
      sel[i]  = 1'b0;
      take[i] = 1'b0;
      case (req_op)
        depq_pkg::OP_POP_MIN: begin
          sel[i]  = (i == 0);
          take[i] = 1'b1;
        end
        depq_pkg::OP_POP_MAX: begin
          sel[i]  = valid_v[i] && !valid_up[i];
          take[i] = !valid_up[i];
        end
        depq_pkg::OP_REMOVE: begin
          sel[i]  = match_v[i] && !suf_up[i];
          take[i] = pre_match[i] && !suf_up[i];
        end
        default: begin
          sel[i]  = 1'b0;
          take[i] = 1'b0;
        end
      endcase
    end

    always_comb begin
      ctrl_a[i].cmp_en = (state == depq_pkg::FSM_CMP);
      ctrl_a[i].mode   = depq_pkg::MODE_HOLD;
      if (commit) begin
        if (req_op == depq_pkg::OP_INSERT) begin
          if (ins_ok && !lt_v[i]) begin
            if (i == 0) begin
              ctrl_a[i].mode = depq_pkg::MODE_LOAD;
            end else if (lt_v[(i == 0) ? 0 : i-1]) begin
              ctrl_a[i].mode = depq_pkg::MODE_LOAD;
            end else begin
              ctrl_a[i].mode = depq_pkg::MODE_FROM_LOW;
            end
          end
        end else if (res_ok && take[i]) begin
          ctrl_a[i].mode = depq_pkg::MODE_FROM_HIGH;
        end
      end
    end

    assign sel_data[i] = (sel[i] && res_ok) ? {prio_a[i], id_a[i]} : '0;
  end

  depq_scan #(.N(CAPACITY)) u_scan_eq (
    .din  (eq_v),
    .dout (pre_eq)
  );

  depq_scan #(.N(CAPACITY)) u_scan_match (
    .din  (match_v),
    .dout (pre_match)
  );

  depq_scan #(.N(CAPACITY)) u_scan_suffix (
    .din  (rev_match),
    .dout (rev_pre)
  );

  depq_or_tree #(.N(CAPACITY), .W(depq_pkg::KEY_W)) u_sel_tree (
    .din  (sel_data),
    .dout (tree_out)
  );

  always_comb begin
    res_status = depq_pkg::ST_EMPTY;
    case (req_op)
      depq_pkg::OP_INSERT: begin
        if (pre_eq[CAPACITY-1])          res_status = depq_pkg::ST_DUP;
        else if (valid_v[CAPACITY-1])    res_status = depq_pkg::ST_FULL;
        else                             res_status = depq_pkg::ST_OK;
      end
      depq_pkg::OP_POP_MIN, depq_pkg::OP_POP_MAX: begin
        res_status = valid_v[0] ? depq_pkg::ST_OK : depq_pkg::ST_EMPTY;
      end
      depq_pkg::OP_REMOVE: begin
        res_status = pre_match[CAPACITY-1] ? depq_pkg::ST_OK : depq_pkg::ST_EMPTY;
      end
      default: res_status = depq_pkg::ST_EMPTY;
    endcase
  end

  // an insert reports ok but removes nothing, so it selects no cell
  assign ins_ok = (req_op == depq_pkg::OP_INSERT) && (res_status == depq_pkg::ST_OK);
  assign res_ok = (req_op != depq_pkg::OP_INSERT) && (res_status == depq_pkg::ST_OK);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      status       <= res_status;
      out_priority <= tree_out[depq_pkg::KEY_W-1:depq_pkg::ID_W];
      out_id       <= tree_out[depq_pkg::ID_W-1:0];
    end
  end

endmodule

// ===== src/depq_checker.sv =====
module depq_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [1:0]                  status,
  input logic [depq_pkg::ID_W-1:0]   out_id,
  input logic [depq_pkg::PRIO_W-1:0] out_priority
);

  // compare cycle always follows a taken beat
  a_busy_after_accept: assert property (
    @(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall
  ) else $error("input taken during compare cycle");

  a_fail_zero: assert property (
    @(posedge clk) disable iff (rst)
    (out_valid && (status != depq_pkg::ST_OK)) |-> (out_id == '0 && out_priority == '0)
  ) else $error("failed result carries a nonzero entry");

  a_reset_idle: assert property (
    @(posedge clk)
    rst |=> !out_valid
  ) else $error("result beat right after reset");

  a_out_hold: assert property (
    @(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(out_id)
                                  && $stable(out_priority))
  ) else $error("stalled result beat changed");

endmodule

bind double_ended_priority_queue depq_checker u_depq_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .status       (status),
  .out_id       (out_id),
  .out_priority (out_priority)
);
